// ===== src/telemetry_frame_builder_crc16_macros.svh =====
// assertion macros shared by the telemetry frame builder rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef TELEMETRY_FRAME_BUILDER_CRC16_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_CRC16_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TFB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tfb_pkg.sv =====
// types, constants and helper functions for the telemetry frame builder
// no dependencies
`default_nettype none

package tfb_pkg;

    localparam int FRAME_LEN = 18;
    localparam int CRC_SPAN  = 16;

    typedef logic [4:0] t_byte_idx;
    typedef logic [7:0] t_byte;

    localparam t_byte_idx LAST_IDX = 5'd17;
    localparam t_byte_idx CRC_HI_IDX = 5'd16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [15:0] DEVICE_ID_RESET = 16'd101;
    localparam logic [15:0] SEQ_RESET       = 16'd1;

    localparam logic [6:0] K_PRIMARY   = 7'd10;
    localparam logic [6:0] K_SECONDARY = 7'd100;

    // one accepted record together with the header words sampled with it
    typedef struct packed {
        logic [15:0]        device_id;
        logic [15:0]        seq_count;
        logic signed [23:0] primary_fx;
        logic signed [23:0] secondary_fx;
        logic signed [23:0] tertiary_fx;
        logic signed [23:0] temperature_fx;
        logic [31:0]        epoch_seconds;
        logic [6:0]         battery_percent;
        logic               critical_flag;
    } t_record;

    // frame bytes 0..15 indexed by wire position
    typedef logic [CRC_SPAN-1:0][7:0] t_frame;

    // round(v * k / 256) half away from zero, saturated to int16
    function automatic logic [15:0] scale_sat16(input logic signed [23:0] v,
                                                input logic [6:0] k);
        logic        neg;
        logic [23:0] mag;
        logic [30:0] prod;
        logic [30:0] sum;
        logic [22:0] r;
        logic [15:0] res;
        neg  = v[23];
        mag  = neg ? 24'(-v) : 24'(v);
        prod = 31'(mag) * 31'(k);
        sum  = prod + 31'd128;
        r    = sum[30:8];
        if (neg) begin
            if (r >= 23'd32768) begin
                res = 16'h8000;
            end else begin
                res = 16'(~r[15:0] + 16'd1);
            end
        end else begin
            if (r > 23'd32767) begin
                res = 16'h7FFF;
            end else begin
                res = r[15:0];
            end
        end
        return res;
    endfunction

    // round(v / 256) half away from zero, saturated to int8
    function automatic logic [7:0] round_sat8(input logic signed [23:0] v);
        logic        neg;
        logic [23:0] mag;
        logic [24:0] sum;
        logic [16:0] r;
        logic [7:0]  res;
        neg = v[23];
        mag = neg ? 24'(-v) : 24'(v);
        sum = 25'(mag) + 25'd128;
        r   = sum[24:8];
        if (neg) begin
            if (r >= 17'd128) begin
                res = 8'h80;
            end else begin
                res = 8'(~r[7:0] + 8'd1);
            end
        end else begin
            if (r > 17'd127) begin
                res = 8'h7F;
            end else begin
                res = r[7:0];
            end
        end
        return res;
    endfunction

    // crc-16-ccitt update by one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/tfb_frame_calc.sv =====
// builds frame bytes 0..15 from one registered record
// depends on tfb_pkg
`default_nettype none

module tfb_frame_calc (
    input  wire tfb_pkg::t_record i_rec,
    output tfb_pkg::t_frame       o_frame
);

    logic [15:0] primary_q;
    logic [15:0] secondary_q;
    logic [15:0] tertiary_q;
    logic [7:0]  temp_q;

    always_comb begin
        primary_q   = tfb_pkg::scale_sat16(i_rec.primary_fx, tfb_pkg::K_PRIMARY);
        secondary_q = tfb_pkg::scale_sat16(i_rec.secondary_fx, tfb_pkg::K_SECONDARY);
        tertiary_q  = tfb_pkg::scale_sat16(i_rec.tertiary_fx, tfb_pkg::K_SECONDARY);
        temp_q      = tfb_pkg::round_sat8(i_rec.temperature_fx);

        o_frame[0]  = i_rec.device_id[15:8];
        o_frame[1]  = i_rec.device_id[7:0];
        o_frame[2]  = i_rec.seq_count[15:8];
        o_frame[3]  = i_rec.seq_count[7:0];
        o_frame[4]  = i_rec.epoch_seconds[31:24];
        o_frame[5]  = i_rec.epoch_seconds[23:16];
        o_frame[6]  = i_rec.epoch_seconds[15:8];
        o_frame[7]  = i_rec.epoch_seconds[7:0];
        o_frame[8]  = primary_q[15:8];
        o_frame[9]  = primary_q[7:0];
        o_frame[10] = secondary_q[15:8];
        o_frame[11] = secondary_q[7:0];
        o_frame[12] = tertiary_q[15:8];
        o_frame[13] = tertiary_q[7:0];
        o_frame[14] = {i_rec.critical_flag, i_rec.battery_percent};
        o_frame[15] = temp_q;
    end

endmodule

`default_nettype wire

// ===== src/telemetry_frame_builder_crc16.sv =====
// telemetry frame builder: sensor record in, 18-byte crc-16 framed packet out
// depends on tfb_pkg, tfb_frame_calc and telemetry_frame_builder_crc16_macros.svh
// path: a record passes the input, frame, serialiser and output registers before byte 0 leaves
// throughput: one frame byte per cycle while i_out_stall is low, set by the byte serialiser
// reset (synchronous, active low): valids clear, sequence to 1, device id to 101
`default_nettype none

`include "telemetry_frame_builder_crc16_macros.svh"

module telemetry_frame_builder_crc16 (
    input  wire               i_clk,
    input  wire               i_rst_n,

    // configuration write channel (device id)
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [15:0]       i_cfg_data,

    // record input channel
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [23:0] i_primary_fx,
    input  wire signed [23:0] i_secondary_fx,
    input  wire signed [23:0] i_tertiary_fx,
    input  wire signed [23:0] i_temperature_fx,
    input  wire  [31:0]       i_epoch_seconds,
    input  wire  [6:0]        i_battery_percent,
    input  wire               i_critical_flag,

    // frame byte output channel
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [7:0]        o_frame_byte,
    output logic [4:0]        o_byte_index,
    output logic              o_last_byte
);

    // configuration and sequence state
    logic [15:0] r_device_id;
    logic [15:0] r_seq;

    // stage 1: registered record plus header words
    logic             r_in_vld;
    tfb_pkg::t_record r_in;

    // stage 2: computed frame bytes 0..15
    logic            r_frm_vld;
    tfb_pkg::t_frame r_frm;
    tfb_pkg::t_frame frm_calc;

    // stage 3: serialiser, running crc updated as bytes leave
    logic               r_ser_vld;
    tfb_pkg::t_frame    r_buf;
    tfb_pkg::t_byte_idx r_idx;
    logic [15:0]        r_crc;

    // output register
    logic               r_out_vld;
    logic [7:0]         r_out_byte;
    tfb_pkg::t_byte_idx r_out_idx;
    logic               r_out_last;

    // handshake and flow control
    logic        in_take;
    logic        ser_last;
    logic        out_load;
    logic        ser_free;
    logic        frm_move;
    logic        in_move;
    logic [7:0]  ser_byte;

    // checking aids: a non-final byte beat, and the output sitting on byte 17
    logic        out_mid;
    logic        out_at_end;

    // config port never back-pressures; writes must only arrive while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    assign in_take  = i_in_valid && !o_in_stall;
    assign ser_last = (r_idx == tfb_pkg::LAST_IDX);
    // output register reloads when empty or when its beat is taken
    assign out_load = r_ser_vld && (!r_out_vld || !i_out_stall);
    // serialiser accepts a new frame when empty or while sending its final byte
    assign ser_free = !r_ser_vld || (out_load && ser_last);
    assign frm_move = r_frm_vld && ser_free;
    assign in_move  = r_in_vld && (!r_frm_vld || frm_move);
    // the input register stays open while it can hand its record forward
    assign o_in_stall = r_in_vld && !in_move;

    assign out_mid    = o_out_valid && !i_out_stall && !o_last_byte;
    assign out_at_end = (o_byte_index == tfb_pkg::LAST_IDX);

    tfb_frame_calc u_frame_calc (
        .i_rec   (r_in),
        .o_frame (frm_calc)
    );

    // byte picked for the wire: payload bytes, then crc high and low
    always_comb begin
        if (r_idx < tfb_pkg::CRC_HI_IDX) begin
            ser_byte = r_buf[r_idx[3:0]];
        end else if (r_idx == tfb_pkg::CRC_HI_IDX) begin
            ser_byte = r_crc[15:8];
        end else begin
            ser_byte = r_crc[7:0];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= tfb_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_id <= i_cfg_data;
        end
    end

    // sequence counter, sampled and advanced on each record beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= tfb_pkg::SEQ_RESET;
        end else if (in_take) begin
            r_seq <= r_seq + 16'd1;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (in_move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.device_id       <= r_device_id;
            r_in.seq_count       <= r_seq;
            r_in.primary_fx      <= i_primary_fx;
            r_in.secondary_fx    <= i_secondary_fx;
            r_in.tertiary_fx     <= i_tertiary_fx;
            r_in.temperature_fx  <= i_temperature_fx;
            r_in.epoch_seconds   <= i_epoch_seconds;
            r_in.battery_percent <= i_battery_percent;
            r_in.critical_flag   <= i_critical_flag;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_vld <= 1'b0;
        end else if (in_move) begin
            r_frm_vld <= 1'b1;
        end else if (frm_move) begin
            r_frm_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_frm <= frm_calc;
        end
    end

    // stage 3: serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_idx     <= '0;
        end else if (frm_move) begin
            r_ser_vld <= 1'b1;
            r_idx     <= '0;
        end else if (out_load) begin
            if (ser_last) begin
                r_ser_vld <= 1'b0;
            end
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frm_move) begin
            r_buf <= r_frm;
            r_crc <= tfb_pkg::CRC_INIT;
        end else if (out_load && (r_idx < tfb_pkg::CRC_HI_IDX)) begin
            r_crc <= tfb_pkg::crc_byte(r_crc, ser_byte);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= ser_byte;
            r_out_idx  <= r_idx;
            r_out_last <= ser_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_frame_byte = r_out_byte;
    assign o_byte_index = r_out_idx;
    assign o_last_byte  = r_out_last;

    // a frame leaves without gaps once started, in index order
    `TFB_ASSERT_NEXT(a_frame_gapless, out_mid, o_out_valid, "gap inside a frame")
    `TFB_ASSERT_NEXT(a_idx_step, out_mid, o_byte_index == $past(o_byte_index) + 5'd1, "index skip")
    // last flag marks exactly the crc low byte
    `TFB_ASSERT_SAME(a_last_flag, o_out_valid, o_last_byte == out_at_end, "last flag wrong")
    // serialiser index stays within the frame
    `TFB_ASSERT_SAME(a_idx_range, r_ser_vld, r_idx <= tfb_pkg::LAST_IDX, "index beyond frame")
    // every record beat advances the sequence counter by one
    `TFB_ASSERT_NEXT(a_seq_step, in_take, r_seq == $past(r_seq) + 16'd1, "sequence not advanced")

endmodule

`default_nettype wire
